// File: rtl/core/mml_pkg.sv
// ----------------------------------------------------------------------------
// mml_pkg: shared types and constants for the Mueller-Muller timing loop
// Word layouts, register map, sequencer states and fixed-point limits.
// ----------------------------------------------------------------------------
package mml_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int SAMPLE_FRAC      = SAMPLE_WIDTH - 2;
  localparam int FRAC_BITS        = 32;
  localparam int OMEGA_WIDTH      = 40;
  localparam int OMEGA_INIT_WIDTH = 39;
  localparam int MU_WIDTH         = 48;
  localparam int GAIN_WIDTH       = 32;
  localparam int LEVEL_WIDTH      = 16;
  localparam int ERR_WIDTH        = 16;

  localparam int CFG_INDEX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH   = 39;

  // shared multiplier: difference or error times history value or gain
  localparam int MUL_A_WIDTH      = SAMPLE_WIDTH + 1;
  localparam int MUL_B_WIDTH      = GAIN_WIDTH + 1;
  localparam int PROD_WIDTH       = MUL_A_WIDTH + MUL_B_WIDTH;
  localparam int ACC_WIDTH        = 36;
  localparam int DELTA_WIDTH      = PROD_WIDTH - SAMPLE_FRAC;

  localparam logic signed [ACC_WIDTH-1:0]   ERR_ONE   = 36'sd268435456;
  localparam logic signed [OMEGA_WIDTH-1:0] OMEGA_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [OMEGA_WIDTH-1:0] OMEGA_MIN = 40'sh80_0000_0000;
  localparam logic signed [MU_WIDTH-1:0]    MU_MAX    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [MU_WIDTH-1:0]    MU_MIN    = 48'sh8000_0000_0000;
  localparam logic signed [MU_WIDTH-1:0]    MU_HALF   = 48'sd2147483648;

  localparam logic [OMEGA_INIT_WIDTH-1:0]   OMEGA_INIT_RST = 39'd4294967296;
  localparam logic [GAIN_WIDTH-1:0]         GAIN_MU_RST    = 32'd42949673;
  localparam logic [GAIN_WIDTH-1:0]         GAIN_OMEGA_RST = 32'd107374;
  localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_NEG_RST  = -16'sd16384;
  localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_POS_RST  = 16'sd16384;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_OMEGA_INIT   = 3'd0,
    REG_GAIN_MU      = 3'd1,
    REG_GAIN_OMEGA   = 3'd2,
    REG_SLICE_NEG_RE = 3'd3,
    REG_SLICE_NEG_IM = 3'd4,
    REG_SLICE_POS_RE = 3'd5,
    REG_SLICE_POS_IM = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ERR,
    ST_GAIN_OMEGA,
    ST_GAIN_MU
  } state_t;

  typedef struct packed {
    logic                           kind;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    logic signed [SAMPLE_WIDTH-1:0] decision_re;
    logic signed [SAMPLE_WIDTH-1:0] decision_im;
  } sample_word_t;

  typedef struct packed {
    logic signed [MU_WIDTH-1:0]    phase_mu;
    logic signed [OMEGA_WIDTH-1:0] period_omega;
    logic signed [ERR_WIDTH-1:0]   timing_error;
  } result_word_t;

endpackage

// File: rtl/core/mueller_muller_timing_loop.sv
// ----------------------------------------------------------------------------
// mueller_muller_timing_loop: complex Mueller-Muller symbol timing loop
// Slices or takes a decision, forms the clamped timing error and updates the
// period (omega) and phase (mu) accumulators through one shared multiplier.
// ----------------------------------------------------------------------------
// Each accepted sample word passes MUL0-MUL3, ERR, GAIN_OMEGA and GAIN_MU before
// its result word is registered; a new word is taken only in IDLE. A single 17x33
// multiplier is used six times per word (four error products, two gain products).
// A result waiting at the output holds the sequencer in its last step only.
// Reset (rst, synchronous): configuration registers to defaults, histories zero, omega
// from omega_init, mu at 0.5. No clearing pass.
module mueller_muller_timing_loop (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  mml_pkg::sample_word_t                  sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output mml_pkg::result_word_t                  result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mml_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [mml_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  localparam int SW = mml_pkg::SAMPLE_WIDTH;
  localparam int OW = mml_pkg::OMEGA_WIDTH;
  localparam int MW = mml_pkg::MU_WIDTH;
  localparam int AW = mml_pkg::ACC_WIDTH;
  localparam int DW = mml_pkg::DELTA_WIDTH;
  localparam int SF = mml_pkg::SAMPLE_FRAC;

  // configuration
  logic [mml_pkg::OMEGA_INIT_WIDTH-1:0] omega_init;
  logic [mml_pkg::GAIN_WIDTH-1:0]       gain_mu;
  logic [mml_pkg::GAIN_WIDTH-1:0]       gain_omega;
  logic signed [SW-1:0]                 slice_neg_re;
  logic signed [SW-1:0]                 slice_neg_im;
  logic signed [SW-1:0]                 slice_pos_re;
  logic signed [SW-1:0]                 slice_pos_im;

  // loop state
  logic signed [SW-1:0] sample_hist_re [2];
  logic signed [SW-1:0] sample_hist_im [2];
  logic signed [SW-1:0] decision_hist_re [2];
  logic signed [SW-1:0] decision_hist_im [2];
  logic signed [OW-1:0] omega_acc;
  logic signed [MW-1:0] mu_acc;

  // current word
  logic signed [SW-1:0] cur_re;
  logic signed [SW-1:0] cur_im;
  logic signed [SW-1:0] dec_re;
  logic signed [SW-1:0] dec_im;
  logic signed [AW-1:0] err_acc;
  logic signed [mml_pkg::ERR_WIDTH-1:0] err;

  mml_pkg::state_t state;
  mml_pkg::state_t state_next;

  logic accept;
  logic commit;
  logic cfg_write;

  logic signed [mml_pkg::MUL_A_WIDTH-1:0] mul_a;
  logic signed [mml_pkg::MUL_B_WIDTH-1:0] mul_b;
  logic signed [mml_pkg::PROD_WIDTH-1:0]  product;
  logic signed [AW-1:0]                   prod_acc;
  logic signed [DW-1:0]                   gain_delta;
  logic signed [AW-1:0]                   err_clamped;
  logic signed [OW+1:0]                   omega_sum;
  logic signed [OW-1:0]                   omega_sat;
  logic signed [MW+1:0]                   mu_sum;
  logic signed [MW-1:0]                   mu_sat;
  logic signed [SW-1:0]                   slice_re;
  logic signed [SW-1:0]                   slice_im;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    cfg_ready    = 1'b0;
    commit       = 1'b0;
    case (state)
      mml_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        cfg_ready    = 1'b1;
        if (sample_valid) begin
          state_next = mml_pkg::ST_MUL0;
        end
      end
      mml_pkg::ST_MUL0:       state_next = mml_pkg::ST_MUL1;
      mml_pkg::ST_MUL1:       state_next = mml_pkg::ST_MUL2;
      mml_pkg::ST_MUL2:       state_next = mml_pkg::ST_MUL3;
      mml_pkg::ST_MUL3:       state_next = mml_pkg::ST_ERR;
      mml_pkg::ST_ERR:        state_next = mml_pkg::ST_GAIN_OMEGA;
      mml_pkg::ST_GAIN_OMEGA: state_next = mml_pkg::ST_GAIN_MU;
      mml_pkg::ST_GAIN_MU: begin
        // previous result word still waiting: hold before touching mu
        if (!(result_valid && result_stall)) begin
          commit     = 1'b1;
          state_next = mml_pkg::ST_IDLE;
        end
      end
      default: state_next = mml_pkg::ST_IDLE;
    endcase
  end

  assign accept    = sample_valid && !sample_stall;
  assign cfg_write = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------- slicer
  assign slice_re = sample.kind ? sample.decision_re :
                    (sample.sample_re > 16'sd0) ? slice_pos_re : slice_neg_re;
  assign slice_im = sample.kind ? sample.decision_im :
                    (sample.sample_im > 16'sd0) ? slice_pos_im : slice_neg_im;

  // ---------------------------------------------------------------- shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      mml_pkg::ST_MUL0: begin
        mul_a = {cur_re[SW-1], cur_re} - {sample_hist_re[1][SW-1], sample_hist_re[1]};
        mul_b = {{(mml_pkg::MUL_B_WIDTH-SW){decision_hist_re[0][SW-1]}}, decision_hist_re[0]};
      end
      mml_pkg::ST_MUL1: begin
        mul_a = {cur_im[SW-1], cur_im} - {sample_hist_im[1][SW-1], sample_hist_im[1]};
        mul_b = {{(mml_pkg::MUL_B_WIDTH-SW){decision_hist_im[0][SW-1]}}, decision_hist_im[0]};
      end
      mml_pkg::ST_MUL2: begin
        mul_a = {dec_re[SW-1], dec_re} - {decision_hist_re[1][SW-1], decision_hist_re[1]};
        mul_b = {{(mml_pkg::MUL_B_WIDTH-SW){sample_hist_re[0][SW-1]}}, sample_hist_re[0]};
      end
      mml_pkg::ST_MUL3: begin
        mul_a = {dec_im[SW-1], dec_im} - {decision_hist_im[1][SW-1], decision_hist_im[1]};
        mul_b = {{(mml_pkg::MUL_B_WIDTH-SW){sample_hist_im[0][SW-1]}}, sample_hist_im[0]};
      end
      mml_pkg::ST_GAIN_OMEGA: begin
        mul_a = {err[mml_pkg::ERR_WIDTH-1], err};
        mul_b = {1'b0, gain_omega};
      end
      mml_pkg::ST_GAIN_MU: begin
        mul_a = {err[mml_pkg::ERR_WIDTH-1], err};
        mul_b = {1'b0, gain_mu};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product    = mul_a * mul_b;
  assign prod_acc   = product[AW-1:0];
  // arithmetic shift right = round toward minus infinity
  assign gain_delta = product[mml_pkg::PROD_WIDTH-1:SF];

  // error clamp to +-1.0 in Q8.28
  always_comb begin
    if (err_acc > mml_pkg::ERR_ONE) begin
      err_clamped = mml_pkg::ERR_ONE;
    end else if (err_acc < -mml_pkg::ERR_ONE) begin
      err_clamped = -mml_pkg::ERR_ONE;
    end else begin
      err_clamped = err_acc;
    end
  end

  // omega and mu updates with saturation
  assign omega_sum = {{2{omega_acc[OW-1]}}, omega_acc}
                   + {{(OW+2-DW){gain_delta[DW-1]}}, gain_delta};

  always_comb begin
    if (omega_sum > $signed({{2{mml_pkg::OMEGA_MAX[OW-1]}}, mml_pkg::OMEGA_MAX})) begin
      omega_sat = mml_pkg::OMEGA_MAX;
    end else if (omega_sum < $signed({{2{mml_pkg::OMEGA_MIN[OW-1]}}, mml_pkg::OMEGA_MIN})) begin
      omega_sat = mml_pkg::OMEGA_MIN;
    end else begin
      omega_sat = omega_sum[OW-1:0];
    end
  end

  assign mu_sum = {{2{mu_acc[MW-1]}}, mu_acc}
                + {{(MW+2-OW){omega_acc[OW-1]}}, omega_acc}
                + {{(MW+2-DW){gain_delta[DW-1]}}, gain_delta};

  always_comb begin
    if (mu_sum > $signed({{2{mml_pkg::MU_MAX[MW-1]}}, mml_pkg::MU_MAX})) begin
      mu_sat = mml_pkg::MU_MAX;
    end else if (mu_sum < $signed({{2{mml_pkg::MU_MIN[MW-1]}}, mml_pkg::MU_MIN})) begin
      mu_sat = mml_pkg::MU_MIN;
    end else begin
      mu_sat = mu_sum[MW-1:0];
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_re <= sample.sample_re;
      cur_im <= sample.sample_im;
      dec_re <= slice_re;
      dec_im <= slice_im;
    end
    case (state)
      mml_pkg::ST_MUL0: err_acc <= prod_acc;
      mml_pkg::ST_MUL1: err_acc <= err_acc + prod_acc;
      mml_pkg::ST_MUL2: err_acc <= err_acc - prod_acc;
      mml_pkg::ST_MUL3: err_acc <= err_acc - prod_acc;
      mml_pkg::ST_ERR:  err     <= err_clamped[SF+mml_pkg::ERR_WIDTH-1:SF];
      default: ;
    endcase
  end

  // configuration registers and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      omega_init   <= mml_pkg::OMEGA_INIT_RST;
      gain_mu      <= mml_pkg::GAIN_MU_RST;
      gain_omega   <= mml_pkg::GAIN_OMEGA_RST;
      slice_neg_re <= mml_pkg::LEVEL_NEG_RST;
      slice_neg_im <= mml_pkg::LEVEL_NEG_RST;
      slice_pos_re <= mml_pkg::LEVEL_POS_RST;
      slice_pos_im <= mml_pkg::LEVEL_POS_RST;
      omega_acc    <= {1'b0, mml_pkg::OMEGA_INIT_RST};
      mu_acc       <= mml_pkg::MU_HALF;
      for (int i = 0; i < 2; i++) begin
        sample_hist_re[i]   <= '0;
        sample_hist_im[i]   <= '0;
        decision_hist_re[i] <= '0;
        decision_hist_im[i] <= '0;
      end
    end else if (cfg_write) begin
      case (mml_pkg::cfg_reg_t'(cfg_index))
        mml_pkg::REG_OMEGA_INIT: begin
          // reload restarts the loop
          omega_init <= cfg_data[mml_pkg::OMEGA_INIT_WIDTH-1:0];
          omega_acc  <= {1'b0, cfg_data[mml_pkg::OMEGA_INIT_WIDTH-1:0]};
          mu_acc     <= mml_pkg::MU_HALF;
          for (int i = 0; i < 2; i++) begin
            sample_hist_re[i]   <= '0;
            sample_hist_im[i]   <= '0;
            decision_hist_re[i] <= '0;
            decision_hist_im[i] <= '0;
          end
        end
        mml_pkg::REG_GAIN_MU:      gain_mu      <= cfg_data[mml_pkg::GAIN_WIDTH-1:0];
        mml_pkg::REG_GAIN_OMEGA:   gain_omega   <= cfg_data[mml_pkg::GAIN_WIDTH-1:0];
        mml_pkg::REG_SLICE_NEG_RE: slice_neg_re <= cfg_data[SW-1:0];
        mml_pkg::REG_SLICE_NEG_IM: slice_neg_im <= cfg_data[SW-1:0];
        mml_pkg::REG_SLICE_POS_RE: slice_pos_re <= cfg_data[SW-1:0];
        mml_pkg::REG_SLICE_POS_IM: slice_pos_im <= cfg_data[SW-1:0];
        default: ;
      endcase
    end else begin
      if (state == mml_pkg::ST_GAIN_OMEGA) begin
        omega_acc <= omega_sat;
      end
      if (commit) begin
        mu_acc              <= mu_sat;
        sample_hist_re[1]   <= sample_hist_re[0];
        sample_hist_im[1]   <= sample_hist_im[0];
        sample_hist_re[0]   <= cur_re;
        sample_hist_im[0]   <= cur_im;
        decision_hist_re[1] <= decision_hist_re[0];
        decision_hist_im[1] <= decision_hist_im[0];
        decision_hist_re[0] <= dec_re;
        decision_hist_im[0] <= dec_im;
      end
    end
  end

  // ---------------------------------------------------------------- output word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.phase_mu     <= mu_sat;
      result.period_omega <= omega_acc;
      result.timing_error <= err;
    end
  end

endmodule
